### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Implication form: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

### rtl/core/s5hp_pkg.sv
`default_nettype none
package s5hp_pkg;

  // protocol constants
  localparam logic [7:0] SOCKS_VER     = 8'd5;
  localparam logic [7:0] CMD_CONNECT   = 8'd1;
  localparam logic [7:0] ATYP_V4       = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
  localparam logic [7:0] ATYP_V6       = 8'd4;
  localparam int         LEN_V4        = 4 + 4 + 2;
  localparam int         LEN_V6        = 4 + 16 + 2;
  localparam int         REPLY_V4      = 10;
  localparam int         REPLY_V6      = 22;
  localparam int         REPLY_GREET   = 2;
  localparam logic [8:0] CNT_MAX       = 9'd511;

  // result kinds
  localparam logic [1:0] KIND_DEST     = 2'd0;
  localparam logic [1:0] KIND_REPLY    = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;
  localparam logic [1:0] KIND_FWD      = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_NO_AUTH    = 3'd2;
  localparam logic [2:0] ST_BAD_CMD    = 3'd3;
  localparam logic [2:0] ST_BAD_ATYP   = 3'd4;
  localparam logic [2:0] ST_BAD_VER    = 3'd5;

  // reported address kinds
  localparam logic [1:0] AT_V4         = 2'd0;
  localparam logic [1:0] AT_DOMAIN     = 2'd1;
  localparam logic [1:0] AT_V6         = 2'd2;

  // reply address type bytes
  localparam logic [7:0] RTYPE_V4      = 8'd1;
  localparam logic [7:0] RTYPE_V6      = 8'd4;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_GREET,
    PH_REQ,
    PH_FWD,
    PH_ERR
  } phase_e;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_ERR,
    JOB_GREET_OK,
    JOB_REQ_OK
  } job_st_e;

  // one queued word of work for the back end
  typedef struct packed {
    logic        item0;   // leading dest or forwarded byte present
    logic        fwd;     // leading byte is forwarded payload
    logic [7:0]  data;
    job_st_e     st;
    logic [2:0]  code;
    logic [1:0]  at;
    logic [15:0] port;
    logic        v6;
  } job_t;

  typedef struct packed {
    phase_e phase;
    logic   push;
  } front_stat_t;

endpackage
`default_nettype wire

### rtl/core/s5hp_front.sv
`default_nettype none
module s5hp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              end_of_message_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output s5hp_pkg::job_t         job_o,
  output s5hp_pkg::front_stat_t  stat_o
);

  s5hp_pkg::phase_e phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  mc_q, mc_d;
  logic        noauth_q, noauth_d;
  logic        vbad_q, vbad_d;
  logic        cbad_q, cbad_d;
  logic [7:0]  rat_q, rat_d;
  logic [7:0]  dl_q, dl_d;
  logic [15:0] port_q, port_d;

  logic        accept;
  logic [8:0]  idx;
  logic [9:0]  len;
  logic [8:0]  dend;
  logic        known;
  logic        dest;
  logic [2:0]  code;
  logic        want_push;
  s5hp_pkg::job_t job;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign idx        = cnt_q;
  assign len        = {1'b0, idx} + 10'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      s5hp_pkg::PH_GREET, s5hp_pkg::PH_REQ: begin
        if (end_of_message_i) begin
          if (code != s5hp_pkg::ST_OK) begin
            phase_d = s5hp_pkg::PH_ERR;
          end else if (phase_q == s5hp_pkg::PH_GREET) begin
            phase_d = s5hp_pkg::PH_REQ;
          end else begin
            phase_d = s5hp_pkg::PH_FWD;
          end
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  // per-byte parse and job build
  always_comb begin
    cnt_d     = (idx != s5hp_pkg::CNT_MAX) ? idx + 9'd1 : idx;
    mc_d      = mc_q;
    noauth_d  = noauth_q;
    vbad_d    = vbad_q;
    cbad_d    = cbad_q;
    rat_d     = rat_q;
    dl_d      = dl_q;
    port_d    = port_q;
    dend      = '0;
    known     = 1'b0;
    dest      = 1'b0;
    code      = s5hp_pkg::ST_OK;
    want_push = 1'b0;
    job       = '0;
    job.st    = s5hp_pkg::JOB_NONE;
    case (phase_q)
      s5hp_pkg::PH_FWD: begin
        job.item0 = 1'b1;
        job.fwd   = 1'b1;
        job.data  = in_byte_i;
        want_push = 1'b1;
      end
      s5hp_pkg::PH_GREET: begin
        if (idx == 9'd0) begin
          vbad_d = (in_byte_i != s5hp_pkg::SOCKS_VER);
        end else if (idx == 9'd1) begin
          mc_d = in_byte_i;
        end else if ((idx - 9'd2) < {1'b0, mc_q} && in_byte_i == 8'd0) begin
          noauth_d = 1'b1;
        end
        if (len <= 10'd2) begin
          code = s5hp_pkg::ST_INCOMPLETE;
        end else if (vbad_d) begin
          code = s5hp_pkg::ST_BAD_VER;
        end else if (len != 10'd2 + {2'b0, mc_d}) begin
          code = s5hp_pkg::ST_INCOMPLETE;
        end else if (!noauth_d) begin
          code = s5hp_pkg::ST_NO_AUTH;
        end
        if (end_of_message_i) begin
          want_push = 1'b1;
          job.code  = code;
          job.st    = (code != s5hp_pkg::ST_OK) ? s5hp_pkg::JOB_ERR : s5hp_pkg::JOB_GREET_OK;
        end
      end
      s5hp_pkg::PH_REQ: begin
        if (idx == 9'd0) begin
          vbad_d = (in_byte_i != s5hp_pkg::SOCKS_VER);
        end else if (idx == 9'd1) begin
          cbad_d = (in_byte_i != s5hp_pkg::CMD_CONNECT);
        end else if (idx == 9'd3) begin
          rat_d = in_byte_i;
        end else if (idx >= 9'd4) begin
          known = 1'b1;
          if (rat_q == s5hp_pkg::ATYP_V4) begin
            dend = 9'd8;
          end else if (rat_q == s5hp_pkg::ATYP_V6) begin
            dend = 9'd20;
          end else if (rat_q == s5hp_pkg::ATYP_DOMAIN) begin
            if (idx == 9'd4) dl_d = in_byte_i;
            dend = 9'd5 + {1'b0, dl_d};
          end else begin
            known = 1'b0;
          end
          if (known) begin
            dest = (rat_q == s5hp_pkg::ATYP_DOMAIN) ? (idx >= 9'd5 && idx < dend)
                                                     : (idx < dend);
            if (!dest && idx >= dend) port_d = {port_q[7:0], in_byte_i};
          end
        end
        if (dest) begin
          job.item0 = 1'b1;
          job.data  = in_byte_i;
          want_push = 1'b1;
        end
        if (len < 10'd10) begin
          code = s5hp_pkg::ST_INCOMPLETE;
        end else if (vbad_d) begin
          code = s5hp_pkg::ST_BAD_VER;
        end else if (cbad_d) begin
          code = s5hp_pkg::ST_BAD_CMD;
        end else if (rat_d == s5hp_pkg::ATYP_V4) begin
          if (len != 10'(s5hp_pkg::LEN_V4)) code = s5hp_pkg::ST_INCOMPLETE;
        end else if (rat_d == s5hp_pkg::ATYP_DOMAIN) begin
          job.at = s5hp_pkg::AT_DOMAIN;
          if (len != 10'd7 + {2'b0, dl_d}) code = s5hp_pkg::ST_INCOMPLETE;
        end else if (rat_d == s5hp_pkg::ATYP_V6) begin
          job.at = s5hp_pkg::AT_V6;
          job.v6 = 1'b1;
          if (len != 10'(s5hp_pkg::LEN_V6)) code = s5hp_pkg::ST_INCOMPLETE;
        end else begin
          code = s5hp_pkg::ST_BAD_ATYP;
        end
        if (end_of_message_i) begin
          want_push = 1'b1;
          job.code  = code;
          if (code != s5hp_pkg::ST_OK) begin
            job.st   = s5hp_pkg::JOB_ERR;
            job.at   = s5hp_pkg::AT_V4;
            job.v6   = 1'b0;
          end else begin
            job.st   = s5hp_pkg::JOB_REQ_OK;
            job.port = port_d;
          end
        end else begin
          job.at = s5hp_pkg::AT_V4;
          job.v6 = 1'b0;
        end
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
    // a message that completes with status OK clears the per-message state
    if ((phase_q == s5hp_pkg::PH_GREET || phase_q == s5hp_pkg::PH_REQ) &&
        end_of_message_i && code == s5hp_pkg::ST_OK) begin
      cnt_d    = '0;
      mc_d     = '0;
      noauth_d = 1'b0;
      vbad_d   = 1'b0;
      cbad_d   = 1'b0;
      rat_d    = '0;
      dl_d     = '0;
      port_d   = '0;
    end
  end

  assign push_o       = accept && want_push;
  assign job_o        = job;
  assign stat_o.phase = phase_q;
  assign stat_o.push  = push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= s5hp_pkg::PH_GREET;
      cnt_q    <= '0;
      mc_q     <= '0;
      noauth_q <= 1'b0;
      vbad_q   <= 1'b0;
      cbad_q   <= 1'b0;
      rat_q    <= '0;
      dl_q     <= '0;
      port_q   <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      mc_q     <= mc_d;
      noauth_q <= noauth_d;
      vbad_q   <= vbad_d;
      cbad_q   <= cbad_d;
      rat_q    <= rat_d;
      dl_q     <= dl_d;
      port_q   <= port_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/s5hp_fifo.sv
`default_nettype none
module s5hp_fifo #(
  parameter int DEPTH = s5hp_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire s5hp_pkg::job_t  wdata_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 vld_o,
  output s5hp_pkg::job_t       rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  s5hp_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL);
  assign vld_o   = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == LAST) ? '0 : wp_q + AW'(1);
      if (do_pop)  rp_q <= (rp_q == LAST) ? '0 : rp_q + AW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule
`default_nettype wire

### rtl/core/s5hp_back.sv
`default_nettype none
module s5hp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_vld_i,
  input  wire s5hp_pkg::job_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [1:0]           res_kind_o,
  output logic [7:0]           res_byte_o,
  output logic [2:0]           status_code_o,
  output logic [1:0]           addr_type_o,
  output logic [15:0]          dest_port_o,
  output logic                 last_result_o
);

  localparam logic [4:0] P_LAST_ERR   = 5'd1;
  localparam logic [4:0] P_LAST_GREET = 5'(1 + s5hp_pkg::REPLY_GREET);
  localparam logic [4:0] P_LAST_V4    = 5'(1 + s5hp_pkg::REPLY_V4);
  localparam logic [4:0] P_LAST_V6    = 5'(1 + s5hp_pkg::REPLY_V6);

  // p: 0 leading byte, 1 status, 2.. reply bytes
  logic [4:0] p_q, p_d, p, last_p, r;
  logic       started_q, started_d;
  logic       load, is_last;
  logic       vld_q, vld_d;
  logic [1:0]  kind_d;
  logic [7:0]  byte_d;
  logic [2:0]  code_d;
  logic [1:0]  at_d;
  logic [15:0] port_d;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [2:0]  code_q;
  logic [1:0]  at_q;
  logic [15:0] port_q;
  logic        last_q;

  assign p = started_q ? p_q : (head_i.item0 ? 5'd0 : 5'd1);
  assign r = p - 5'd2;

  always_comb begin
    case (head_i.st)
      s5hp_pkg::JOB_NONE:     last_p = 5'd0;
      s5hp_pkg::JOB_ERR:      last_p = P_LAST_ERR;
      s5hp_pkg::JOB_GREET_OK: last_p = P_LAST_GREET;
      s5hp_pkg::JOB_REQ_OK:   last_p = head_i.v6 ? P_LAST_V6 : P_LAST_V4;
      default:                last_p = 5'd0;
    endcase
  end

  assign is_last = (p == last_p);
  assign load    = head_vld_i && (!vld_q || !out_stall_i);
  assign pop_o   = load && is_last;

  // item at the current step
  always_comb begin
    kind_d = s5hp_pkg::KIND_REPLY;
    byte_d = '0;
    code_d = s5hp_pkg::ST_OK;
    at_d   = s5hp_pkg::AT_V4;
    port_d = '0;
    if (p == 5'd0) begin
      kind_d = head_i.fwd ? s5hp_pkg::KIND_FWD : s5hp_pkg::KIND_DEST;
      byte_d = head_i.data;
    end else if (p == 5'd1) begin
      kind_d = s5hp_pkg::KIND_STATUS;
      code_d = head_i.code;
      at_d   = head_i.at;
      port_d = head_i.port;
    end else if (r == 5'd0) begin
      byte_d = s5hp_pkg::SOCKS_VER;
    end else if (r == 5'd3 && head_i.st == s5hp_pkg::JOB_REQ_OK) begin
      byte_d = head_i.v6 ? s5hp_pkg::RTYPE_V6 : s5hp_pkg::RTYPE_V4;
    end
  end

  always_comb begin
    p_d       = p_q;
    started_d = started_q;
    vld_d     = vld_q;
    if (load) begin
      vld_d     = 1'b1;
      started_d = !is_last;
      p_d       = p + 5'd1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q       <= '0;
      started_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      p_q       <= p_d;
      started_q <= started_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      code_q <= code_d;
      at_q   <= at_d;
      port_q <= port_d;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = vld_q;
  assign res_kind_o    = kind_q;
  assign res_byte_o    = byte_q;
  assign status_code_o = code_q;
  assign addr_type_o   = at_q;
  assign dest_port_o   = port_q;
  assign last_result_o = last_q;

endmodule
`default_nettype wire

### rtl/core/socks5_handshake_parser_unit.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | in_byte_i, end_of_message_i
// out     | output    | out_valid_o / out_stall_i| res_kind_o, res_byte_o, status_code_o,
//         |           |                          | addr_type_o, dest_port_o, last_result_o
//
// Input: one byte per cycle while in_stall_o is low; the parser updates its counters in the accept cycle.
// Output: one result word per cycle while out_stall_i is low, from a registered output stage.
// A byte yields 0 to 23 results; the back end emits them in order, so a successful request
// (status plus 22 reply bytes) holds the head of the job queue until its last reply byte is sent.
// in_stall_o is high exactly while the job queue (QDEPTH entries) is full.
// Reset is asynchronous: greeting phase, counters cleared, queue and output emptied.
`default_nettype none
`include "assert_macros.svh"
module socks5_handshake_parser_unit #(
  parameter int QDEPTH = s5hp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       res_kind_o,
  output logic [7:0]       res_byte_o,
  output logic [2:0]       status_code_o,
  output logic [1:0]       addr_type_o,
  output logic [15:0]      dest_port_o,
  output logic             last_result_o
);

  // front end -> queue
  logic                  push;
  logic                  q_full;
  s5hp_pkg::job_t        job_w;
  s5hp_pkg::front_stat_t fstat;

  // queue -> back end
  logic                  head_vld;
  logic                  pop;
  s5hp_pkg::job_t        head;

  // Front: per-byte parsing of greeting and request, one job word per
  // byte that produces any result.
  s5hp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .job_o            (job_w),
    .stat_o           (fstat)
  );

  // Short job queue decouples byte intake from reply expansion.
  s5hp_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_w),
    .full_o  (q_full),
    .pop_i   (pop),
    .vld_o   (head_vld),
    .rdata_o (head)
  );

  // Back: steps through each job's results (leading byte, status, reply).
  s5hp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_vld_i    (head_vld),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_kind_o    (res_kind_o),
    .res_byte_o    (res_byte_o),
    .status_code_o (status_code_o),
    .addr_type_o   (addr_type_o),
    .dest_port_o   (dest_port_o),
    .last_result_o (last_result_o)
  );

  // error phase is silent and sticky
  `ASSERT_IMPL(a_err_silent, fstat.phase == s5hp_pkg::PH_ERR, !fstat.push, "job pushed in error phase")
  `ASSERT_NEXT(a_err_sticky, fstat.phase == s5hp_pkg::PH_ERR, fstat.phase == s5hp_pkg::PH_ERR, "left error phase")
  // only status words carry a code
  `ASSERT_IMPL(a_code_status, out_valid_o && res_kind_o != s5hp_pkg::KIND_STATUS, status_code_o == s5hp_pkg::ST_OK, "code on non-status word")
  // a forwarded byte is always the only result of its byte
  `ASSERT_IMPL(a_fwd_last, out_valid_o && res_kind_o == s5hp_pkg::KIND_FWD, last_result_o, "forwarded word not last")

endmodule
`default_nettype wire

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import s5hp_pkg::*;

  // Longest stretch with no handshake on either side before the run is called hung.
  // Worst case is a 79% output stall run; the limit sits far beyond that.
  localparam int QUIET_LIMIT = 4000;
  // Cycles to keep watching after the last expected word, so that stray words still
  // in the queue or the output register show up.
  localparam int DRAIN_CYCLES = 64;
  // Rough size of the byte stream fed to the parser.
  localparam int STREAM_BYTES = 470;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [2:0]  code;
    logic [1:0]  at;
    logic [15:0] port;
    logic        last;
  } hs_word_t;

  // Tracks the handshake state and holds the words each accepted byte should cause.
  class handshake_scoreboard;
    phase_e      ph;
    logic [8:0]  taken;       // bytes already seen in the current message, saturating
    logic [7:0]  n_methods;
    bit          no_auth_ok;
    bit          ver_bad;
    bit          cmd_bad;
    logic [7:0]  atyp_raw;
    logic [7:0]  dom_len;
    logic [15:0] port_acc;    // bytes after the destination, shifted in from the low end
    hs_word_t    expected_words[$];
    int          errors;

    function new();
      ph = PH_GREET;
      errors = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      taken = '0;
      n_methods = '0;
      no_auth_ok = 1'b0;
      ver_bad = 1'b0;
      cmd_bad = 1'b0;
      atyp_raw = '0;
      dom_len = '0;
      port_acc = '0;
    endfunction

    function void queue_word(logic [1:0] kind, logic [7:0] data, logic [2:0] code,
                             logic [1:0] at, logic [15:0] port);
      hs_word_t w;
      w = '{kind, data, code, at, port, 1'b0};
      expected_words.push_back(w);
    endfunction

    // Work out the words caused by one accepted byte.
    function void note_byte(logic [7:0] b, logic eom);
      int         idx;
      int         len;
      int         dend;
      int         rlen;
      int         mark;
      logic [2:0] code;
      logic [1:0] at;
      logic [7:0] rtype;
      bit         known;
      bit         is_dest;
      idx = int'(taken);
      len = idx + 1;
      mark = expected_words.size();
      code = ST_OK;
      taken = (taken < CNT_MAX) ? taken + 9'd1 : CNT_MAX;
      case (ph)
        PH_FWD: begin
          // after a good request every byte passes through, end flag ignored
          queue_word(KIND_FWD, b, ST_OK, AT_V4, 16'd0);
        end
        PH_GREET: begin
          if (idx == 0) ver_bad = (b != SOCKS_VER);
          else if (idx == 1) n_methods = b;
          else if (idx - 2 < n_methods && b == 8'd0) no_auth_ok = 1'b1;
          if (eom) begin
            if (len <= 2) code = ST_INCOMPLETE;
            else if (ver_bad) code = ST_BAD_VER;
            else if (len != 2 + n_methods) code = ST_INCOMPLETE;
            else if (!no_auth_ok) code = ST_NO_AUTH;
            queue_word(KIND_STATUS, 8'd0, code, AT_V4, 16'd0);
            if (code != ST_OK) begin
              ph = PH_ERR;
            end else begin
              queue_word(KIND_REPLY, SOCKS_VER, ST_OK, AT_V4, 16'd0);
              queue_word(KIND_REPLY, 8'd0, ST_OK, AT_V4, 16'd0);
              clear_msg();
              ph = PH_REQ;
            end
          end
        end
        PH_REQ: begin
          dend = 0;
          known = 1'b1;
          if (idx == 0) ver_bad = (b != SOCKS_VER);
          else if (idx == 1) cmd_bad = (b != CMD_CONNECT);
          else if (idx == 3) atyp_raw = b;
          else if (idx >= 4) begin
            if (atyp_raw == ATYP_V4) dend = 8;
            else if (atyp_raw == ATYP_V6) dend = 20;
            else if (atyp_raw == ATYP_DOMAIN) begin
              if (idx == 4) dom_len = b;
              dend = 5 + dom_len;
            end else known = 1'b0;
            if (known) begin
              // the domain length byte itself is not streamed
              is_dest = (atyp_raw == ATYP_DOMAIN) ? (idx >= 5 && idx < dend) : (idx < dend);
              if (is_dest) queue_word(KIND_DEST, b, ST_OK, AT_V4, 16'd0);
              else if (idx >= dend) port_acc = {port_acc[7:0], b};
            end
          end
          if (eom) begin
            at = AT_V4;
            rlen = REPLY_V4;
            rtype = RTYPE_V4;
            if (len < LEN_V4) code = ST_INCOMPLETE;
            else if (ver_bad) code = ST_BAD_VER;
            else if (cmd_bad) code = ST_BAD_CMD;
            else if (atyp_raw == ATYP_V4) begin
              if (len != LEN_V4) code = ST_INCOMPLETE;
            end else if (atyp_raw == ATYP_DOMAIN) begin
              at = AT_DOMAIN;
              if (len != 7 + dom_len) code = ST_INCOMPLETE;
            end else if (atyp_raw == ATYP_V6) begin
              at = AT_V6;
              rlen = REPLY_V6;
              rtype = RTYPE_V6;
              if (len != LEN_V6) code = ST_INCOMPLETE;
            end else code = ST_BAD_ATYP;
            if (code != ST_OK) begin
              queue_word(KIND_STATUS, 8'd0, code, AT_V4, 16'd0);
              ph = PH_ERR;
            end else begin
              queue_word(KIND_STATUS, 8'd0, ST_OK, at, port_acc);
              queue_word(KIND_REPLY, SOCKS_VER, ST_OK, AT_V4, 16'd0);
              queue_word(KIND_REPLY, 8'd0, ST_OK, AT_V4, 16'd0);
              queue_word(KIND_REPLY, 8'd0, ST_OK, AT_V4, 16'd0);
              queue_word(KIND_REPLY, rtype, ST_OK, AT_V4, 16'd0);
              for (int k = 4; k < rlen; k++) queue_word(KIND_REPLY, 8'd0, ST_OK, AT_V4, 16'd0);
              clear_msg();
              ph = PH_FWD;
            end
          end
        end
        default: ;  // error phase: silent until reset
      endcase
      if (expected_words.size() > mark)
        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    function void field_mismatch(string name, int unsigned exp_v, int unsigned act_v);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      errors++;
    endfunction

    // Compare one accepted output word with the oldest pending one.
    function void check_word(hs_word_t got);
      hs_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, kind %0d byte 0x%0h code %0d", $time,
                 got.kind, got.data, got.code);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (got.kind !== w.kind) field_mismatch("res_kind", w.kind, got.kind);
        if (got.data !== w.data) field_mismatch("res_byte", w.data, got.data);
        if (got.code !== w.code) field_mismatch("status_code", w.code, got.code);
        if (got.at !== w.at) field_mismatch("addr_type", w.at, got.at);
        if (got.port !== w.port) field_mismatch("dest_port", w.port, got.port);
        if (got.last !== w.last) field_mismatch("last_result", w.last, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'd0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  res_kind_o;
  logic [7:0]  res_byte_o;
  logic [2:0]  status_code_o;
  logic [1:0]  addr_type_o;
  logic [15:0] dest_port_o;
  logic        last_result_o;

  socks5_handshake_parser_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .res_kind_o       (res_kind_o),
    .res_byte_o       (res_byte_o),
    .status_code_o    (status_code_o),
    .addr_type_o      (addr_type_o),
    .dest_port_o      (dest_port_o),
    .last_result_o    (last_result_o)
  );

  handshake_scoreboard sb = new();

  // byte stream to feed, built before reset
  logic [7:0] tx_data[$];
  bit         tx_eom[$];

  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int quiet = 0;           // cycles since the last handshake

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Both channels are sampled at the edge, before any NBA update lands.
  // Input is noted first; output words always trail their byte, as each job passes the queue and output register.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_byte(in_byte_i, end_of_message_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(hs_word_t'{res_kind_o, res_byte_o, status_code_o, addr_type_o,
                               dest_port_o, last_result_o});
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add_byte(logic [7:0] b, bit eom);
    tx_data.push_back(b);
    tx_eom.push_back(eom);
  endfunction

  // leans on the edges of the byte range
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] any_byte_but(logic [7:0] v);
    logic [7:0] r;
    do r = any_byte(); while (r == v);
    return r;
  endfunction

  function automatic logic [7:0] any_atyp();
    case ($urandom_range(0, 2))
      0: return ATYP_V4;
      1: return ATYP_DOMAIN;
      default: return ATYP_V6;
    endcase
  endfunction

  // domain length: mostly short, now and then the full 255
  function automatic int any_dlen();
    return ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(3, 30);
  endfunction

  // Greeting: version, method count, nm method bytes. Methods are nonzero except one zero,
  // placed inside the counted range (anywhere when the count is 0), when with_zero is set.
  function automatic void add_greeting(logic [7:0] ver, logic [7:0] mc, int nm, bit with_zero);
    int         lim;
    int         zpos;
    logic [7:0] m;
    add_byte(ver, 1'b0);
    add_byte(mc, nm == 0);
    lim = (mc < nm) ? mc : nm;
    if (lim == 0) lim = nm;
    zpos = -1;
    if (with_zero && nm > 0) zpos = $urandom_range(0, lim - 1);
    for (int i = 0; i < nm; i++) begin
      m = any_byte_but(8'd0);
      if (i == zpos) m = 8'd0;
      add_byte(m, i == nm - 1);
    end
  endfunction

  // Request: header, destination for the given type, port; adj adds or trims bytes.
  function automatic void add_request(logic [7:0] ver, logic [7:0] cmd, logic [7:0] atyp,
                                      int dl, int adj);
    logic [7:0] msg[$];
    int         alen;
    msg.push_back(ver);
    msg.push_back(cmd);
    msg.push_back(any_byte());  // reserved byte, never checked
    msg.push_back(atyp);
    if (atyp == ATYP_DOMAIN) begin
      msg.push_back(8'(dl));
      alen = dl;
    end else if (atyp == ATYP_V6) begin
      alen = 16;
    end else begin
      alen = 4;
    end
    repeat (alen + 2) msg.push_back(any_byte());
    if (adj > 0) repeat (adj) msg.push_back(any_byte());
    else repeat (-adj) if (msg.size() > 1) void'(msg.pop_back());
    foreach (msg[i]) add_byte(msg[i], i == msg.size() - 1);
  endfunction

  // Present one byte, then hold it until the parser takes it.
  task automatic drive_byte(logic [7:0] b, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int unsigned pick;
    int          total;
    int          fwd_n;
    int          mc;
    int          nm;
    logic [7:0]  atyp;
    logic [7:0]  v;

    // An error locks the parser until reset and reset comes only once, so each
    // run takes one path: full success into forwarding, or one error case.
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      // good greeting; sometimes the full 255-method list
      mc = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 8);
      add_greeting(SOCKS_VER, 8'(mc), mc, 1'b1);
    end
    if (pick < 12) begin
      atyp = any_atyp();
      add_request(SOCKS_VER, CMD_CONNECT, atyp, any_dlen(), 0);
      // forwarded payload makes up the bulk; end flag must be ignored here
      fwd_n = STREAM_BYTES - tx_data.size();
      if (fwd_n < 150) fwd_n = 150;
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b0);
      repeat (fwd_n) add_byte(any_byte(), $urandom_range(0, 7) == 0);
    end else if (pick < 15) begin
      case ($urandom_range(0, 5))
        0: add_request(any_byte(), any_byte(), ATYP_V4, 0, -int'($urandom_range(1, 9)));
        1: add_request(any_byte_but(SOCKS_VER), CMD_CONNECT, any_atyp(), any_dlen(), 0);
        2: add_request(SOCKS_VER, any_byte_but(CMD_CONNECT), any_atyp(), any_dlen(), 0);
        3: begin
          // any type byte other than the three known ones
          do atyp = any_byte(); while (atyp == ATYP_V4 || atyp == ATYP_DOMAIN || atyp == ATYP_V6);
          add_request(SOCKS_VER, CMD_CONNECT, atyp, 0, 0);
        end
        4: begin
          atyp = any_atyp();
          nm = $urandom_range(1, 4);
          if (atyp != ATYP_V4 && $urandom_range(0, 1) == 0) nm = -nm;
          add_request(SOCKS_VER, CMD_CONNECT, atyp, any_dlen(), nm);
        end
        default: add_request(SOCKS_VER, CMD_CONNECT, ATYP_DOMAIN, $urandom_range(0, 255), 520);
      endcase
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          // two bytes or fewer: too short, version not even looked at
          if ($urandom_range(0, 1) == 0) begin
            add_byte(any_byte(), 1'b1);
          end else begin
            add_byte(any_byte(), 1'b0);
            add_byte(any_byte(), 1'b1);
          end
        end
        1: begin
          mc = $urandom_range(1, 8);
          add_greeting(any_byte_but(SOCKS_VER), 8'(mc), mc, 1'b1);
        end
        2: begin
          // method list length disagrees with the count
          mc = $urandom_range(0, 20);
          if (mc == 0) nm = $urandom_range(1, 4);
          else if ($urandom_range(0, 1) == 0) nm = mc + $urandom_range(1, 3);
          else nm = mc - 1;
          add_greeting(SOCKS_VER, 8'(mc), nm, 1'b1);
        end
        3: begin
          mc = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 8);
          add_greeting(SOCKS_VER, 8'(mc), mc, 1'b0);
        end
        default: add_greeting(SOCKS_VER, 8'd255, 520, 1'b1);  // byte count saturates
      endcase
    end
    if (pick >= 12) begin
      // after the error the parser must stay silent, for the rest of the stream
      repeat (8) begin
        v = any_byte();
        add_byte(v, $urandom_range(0, 1) == 1);
      end
      while (tx_data.size() < STREAM_BYTES) add_byte(any_byte(), $urandom_range(0, 1) == 1);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idling phases by quarter of the stream: none, sender, receiver, both light
    total = tx_data.size();
    for (int i = 0; i < total; i++) begin
      case ((i * 4) / total)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      drive_byte(tx_data[i], tx_eom[i]);
    end
    in_valid_i <= 1'b0;
    // let the monitor note the last byte before looking at the pending words
    @(posedge clk_i);

    // the watchdog catches words that never show up
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/s5hp_pkg.sv
rtl/core/s5hp_front.sv
rtl/core/s5hp_fifo.sv
rtl/core/s5hp_back.sv
rtl/core/socks5_handshake_parser_unit.sv
tb/sv/testbench.sv
